// ----- hw/rtl/ofve_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ofve_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 168;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_WEIGHT = 3'd6;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  // cosine rom, quarter wave
  localparam int          COS_DEPTH   = 512;
  localparam int          COS_IDX_W   = $clog2(COS_DEPTH);
  localparam int          ANGLE_W     = 14;
  localparam int          ANGLE_RIGHT = 9000;
  localparam int          COS_SHIFT   = 2 * ANGLE_W + COS_IDX_W;
  localparam int          COS_KW      = 2 * COS_IDX_W + ANGLE_W + 1;
  localparam int          COS_PROD_W  = ANGLE_W + COS_KW;
  localparam logic [63:0] COS_RECIP   =
    ((64'd1 << COS_SHIFT) + 64'(ANGLE_RIGHT) - 64'd1) / 64'(ANGLE_RIGHT);
  localparam logic [COS_KW-1:0] COS_MULT = COS_KW'(64'(COS_DEPTH) * COS_RECIP);
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [15:0] cos_rom_t [COS_DEPTH];

  typedef struct packed {
    logic go;
    logic scale_en;
  } lane_ctrl_t;

  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series of cos in q30, rounded to q1.15
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t           rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] acc;
    for (int i = 0; i < COS_DEPTH; i++) begin
      x    = (64'(i) * PI_Q30) >> (COS_IDX_W + 1);
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = $signed(term);
      for (int k = 1; k <= 8; k++) begin
        term = div_u64((term * x2) >> 30, (64'd2 * 64'(k) - 64'd1) * (64'd2 * 64'(k)));
        if ((k & 1) != 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = 64'sd0;
      end
      q = ($unsigned(acc) + (64'd1 << 14)) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      rom[i] = q[15:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/optical_flow_velocity_estimator.sv -----
// a request runs from acceptance to result valid by one of three paths: a failed frame goes
// straight to the update, an out-of-range one through the lane and the update, an in-range one
// through cosine rom, hand-off, height, lane, hand-off and update
// throughput: one poll at a time; the next poll can be taken in the same cycle that the result
// turns valid, and the update waits while a previous result is not yet taken
// reset: synchronous, clears all filter and sample state, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module optical_flow_velocity_estimator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // range, flow_x, flow_y, quality, roll, pitch, rate_x, rate_y
  input  wire logic [ofve_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // frame_ok
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // distance, quality, flow_x, flow_y, height, scaled_x, scaled_y,
  // filtered_x, filtered_y, sample_total
  output logic [ofve_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // sample_valid
  output logic                                   m_axis_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ofve_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ofve_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ofve_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_COS  = 7'b0000010,
    ST_HGT1 = 7'b0000100,
    ST_HGT2 = 7'b0001000,
    ST_HGT3 = 7'b0010000,
    ST_LANE = 7'b0100000,
    ST_UPD  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0] min_dist;
  logic [15:0] max_dist;
  logic [15:0] min_cos;
  logic [15:0] min_height;
  logic [15:0] vel_gain;
  logic [23:0] gyro_gain;
  logic [16:0] old_weight;
  logic [16:0] w_eff;

  logic              frame_ok;
  logic              win;
  logic [15:0]       dist_in;
  logic signed [7:0] fx_in;
  logic signed [7:0] fy_in;
  logic [7:0]        qual_in;
  logic [15:0]       roll_in;
  logic [15:0]       pitch_in;
  logic signed [15:0] rx_in;
  logic signed [15:0] ry_in;

  logic        accept;
  logic        in_win;
  logic        out_free;
  logic        cos_go;
  logic        lane_go;
  logic        scale_en;
  lane_ctrl_t  lane_ctrl;
  logic        roll_done;
  logic        pitch_done;
  logic [15:0] roll_cos;
  logic [15:0] pitch_cos;
  logic [31:0] p1;
  logic [47:0] hp;
  logic [19:0] h_cur;
  logic        x_done;
  logic        y_done;
  logic signed [18:0] x_scaled;
  logic signed [18:0] y_scaled;
  logic signed [18:0] x_filt;
  logic signed [18:0] y_filt;

  logic               valid_flag;
  logic [15:0]        last_distance;
  logic [7:0]         last_quality;
  logic signed [7:0]  last_flow_x;
  logic signed [7:0]  last_flow_y;
  logic [19:0]        last_height;
  logic signed [18:0] scaled_x;
  logic signed [18:0] scaled_y;
  logic signed [18:0] filter_x;
  logic signed [18:0] filter_y;
  logic [31:0]        good_samples;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_win        = (s_axis_tdata[15:0] > min_dist) && (s_axis_tdata[15:0] < max_dist);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign w_eff         = (old_weight > WEIGHT_ONE) ? WEIGHT_ONE : old_weight;
  assign hp            = 48'(p1) * 48'(pitch_cos);
  assign lane_ctrl     = '{go: lane_go, scale_en: scale_en};

  assign m_axis_tuser = valid_flag;
  assign m_axis_tdata = {good_samples, filter_y, filter_x, scaled_y, scaled_x,
                         last_height, last_flow_y, last_flow_x, last_quality,
                         last_distance};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist   <= 16'd20;
      max_dist   <= 16'd3000;
      min_cos    <= 16'd23167;
      min_height <= 16'd100;
      vel_gain   <= 16'd578;
      gyro_gain  <= 24'd1464;
      old_weight <= 17'd55706;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_DIST:   min_dist   <= cfg_data[15:0];
        REG_MAX_DIST:   max_dist   <= cfg_data[15:0];
        REG_MIN_COS:    min_cos    <= cfg_data[15:0];
        REG_MIN_HEIGHT: min_height <= cfg_data[15:0];
        REG_VEL_GAIN:   vel_gain   <= cfg_data[15:0];
        REG_GYRO_GAIN:  gyro_gain  <= cfg_data[23:0];
        REG_OLD_WEIGHT: old_weight <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!s_axis_tuser) begin
            state_next = ST_UPD;
          end else if (!in_win) begin
            state_next = ST_LANE;
          end else begin
            state_next = ST_COS;
          end
        end
      end
      ST_COS: begin
        if (roll_done && pitch_done) begin
          state_next = ST_HGT1;
        end
      end
      ST_HGT1: state_next = ST_HGT2;
      ST_HGT2: state_next = ST_HGT3;
      ST_HGT3: state_next = ST_LANE;
      ST_LANE: begin
        if (x_done && y_done) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cos_go        <= 1'b0;
      lane_go       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      cos_go  <= accept && s_axis_tuser && in_win;
      lane_go <= (state == ST_HGT3) || (accept && s_axis_tuser && !in_win);
      if ((state == ST_UPD) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // request capture and height
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_ok <= s_axis_tuser;
      win      <= in_win;
      dist_in  <= s_axis_tdata[15:0];
      fx_in    <= s_axis_tdata[23:16];
      fy_in    <= s_axis_tdata[31:24];
      qual_in  <= s_axis_tdata[39:32];
      roll_in  <= s_axis_tdata[55:40];
      pitch_in <= s_axis_tdata[71:56];
      rx_in    <= s_axis_tdata[87:72];
      ry_in    <= s_axis_tdata[103:88];
    end
    if (accept) begin
      scale_en <= 1'b0;
    end else if (state == ST_HGT3) begin
      scale_en <= {4'd0, h_cur} > {8'd0, min_height, 4'd0};
    end
    p1 <= 32'(dist_in) * 32'(roll_cos);
    if (state == ST_HGT2) begin
      h_cur <= (hp[47:46] != 2'd0) ? 20'hFFFFF : hp[45:26];
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_flag    <= 1'b0;
      last_distance <= '0;
      last_quality  <= '0;
      last_flow_x   <= '0;
      last_flow_y   <= '0;
      last_height   <= '0;
      scaled_x      <= '0;
      scaled_y      <= '0;
      filter_x      <= '0;
      filter_y      <= '0;
      good_samples  <= '0;
    end else if ((state == ST_UPD) && out_free && frame_ok) begin
      last_distance <= dist_in;
      last_quality  <= qual_in;
      filter_x      <= x_filt;
      filter_y      <= y_filt;
      if (!win) begin
        valid_flag <= 1'b0;
      end else begin
        valid_flag   <= 1'b1;
        last_flow_x  <= fx_in;
        last_flow_y  <= fy_in;
        last_height  <= h_cur;
        good_samples <= good_samples + 32'd1;
        scaled_x     <= scale_en ? x_scaled : 19'sd0;
        scaled_y     <= scale_en ? y_scaled : 19'sd0;
      end
    end
  end

  ofve_cos u_cos_roll (
    .clk     (clk),
    .rst     (rst),
    .go      (cos_go),
    .angle   (roll_in),
    .min_cos (min_cos),
    .done    (roll_done),
    .cos_val (roll_cos)
  );

  ofve_cos u_cos_pitch (
    .clk     (clk),
    .rst     (rst),
    .go      (cos_go),
    .angle   (pitch_in),
    .min_cos (min_cos),
    .done    (pitch_done),
    .cos_val (pitch_cos)
  );

  ofve_lane u_lane_x (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .height     (h_cur),
    .flow       (fx_in),
    .rate       (ry_in),
    .filter_in  (filter_x),
    .vel_gain   (vel_gain),
    .gyro_gain  (gyro_gain),
    .old_w      (w_eff),
    .done       (x_done),
    .scaled     (x_scaled),
    .filter_out (x_filt)
  );

  ofve_lane u_lane_y (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .height     (h_cur),
    .flow       (fy_in),
    .rate       (rx_in),
    .filter_in  (filter_y),
    .vel_gain   (vel_gain),
    .gyro_gain  (gyro_gain),
    .old_w      (w_eff),
    .done       (y_done),
    .scaled     (y_scaled),
    .filter_out (y_filt)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ofve_cos.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofve_cos (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [15:0] angle,
  input  wire logic [15:0] min_cos,
  output logic             done,
  output logic [15:0]      cos_val
);
  import ofve_pkg::*;

  localparam cos_rom_t ROM = build_cos_rom();

  logic [15:0]            mag;
  logic [15:0]            fold;
  logic                   beyond;
  logic [COS_PROD_W-1:0]  prod;
  logic [COS_IDX_W-1:0]   idx;
  logic                   zero1;
  logic                   zero2;
  logic [15:0]            rom_q;
  logic [15:0]            raw_cos;
  logic [1:0]             step;

  always_comb begin
    mag     = angle[15] ? 16'(-angle) : angle;
    fold    = (mag > 16'd18000) ? 16'(16'd36000 - mag) : mag;
    beyond  = fold >= 16'(ANGLE_RIGHT);
    idx     = prod[COS_SHIFT +: COS_IDX_W];
    raw_cos = zero2 ? 16'd0 : rom_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      step <= {step[0], go};
      done <= step[1];
    end
  end

  always_ff @(posedge clk) begin
    prod    <= COS_PROD_W'(fold[ANGLE_W-1:0]) * COS_PROD_W'(COS_MULT);
    zero1   <= beyond;
    rom_q   <= ROM[idx];
    zero2   <= zero1;
    cos_val <= (raw_cos < min_cos) ? min_cos : raw_cos;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ofve_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ofve_lane (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ofve_pkg::lane_ctrl_t     ctrl,
  input  wire logic [19:0]              height,
  input  wire logic signed [7:0]        flow,
  input  wire logic signed [15:0]       rate,
  input  wire logic signed [18:0]       filter_in,
  input  wire logic [15:0]              vel_gain,
  input  wire logic [23:0]              gyro_gain,
  input  wire logic [16:0]              old_w,
  output logic                          done,
  output logic signed [18:0]            scaled,
  output logic signed [18:0]            filter_out
);
  import ofve_pkg::*;

  function automatic logic signed [18:0] sat19(input logic signed [63:0] v);
    logic signed [18:0] r;
    if (v > 64'sd262143) begin
      r = 19'sd262143;
    end else if (v < -64'sd262144) begin
      r = -19'sd262144;
    end else begin
      r = v[18:0];
    end
    return r;
  endfunction

  logic [3:0]          step;
  logic [16:0]         new_w;
  logic signed [20:0]  h_s;
  logic signed [28:0]  p_fl;
  logic signed [36:0]  p_rt;
  logic signed [45:0]  p_sc;
  logic signed [61:0]  p_gy;
  logic signed [45:0]  sc_rnd;
  logic signed [61:0]  gy_rnd;
  logic signed [18:0]  sc_sat;
  logic signed [38:0]  comp_val;
  logic signed [38:0]  comp;
  logic signed [36:0]  p_old;
  logic signed [56:0]  p_new;
  logic signed [57:0]  sum;
  logic signed [57:0]  tr;

  always_comb begin
    new_w    = 17'(WEIGHT_ONE - old_w);
    h_s      = $signed({1'b0, height});
    sc_rnd   = p_sc + (p_sc[45] ? 46'sd32767 : 46'sd32768);
    gy_rnd   = p_gy + (p_gy[61] ? 62'sd8388607 : 62'sd8388608);
    sc_sat   = sat19({{34{sc_rnd[45]}}, sc_rnd[45:16]});
    comp_val = {{20{sc_sat[18]}}, sc_sat} - {gy_rnd[61], gy_rnd[61:24]};
    sum      = {{21{p_old[36]}}, p_old} + {p_new[56], p_new};
    tr       = sum + (sum[57] ? 58'sd65535 : 58'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      step <= {step[2:0], ctrl.go};
      done <= step[3];
    end
  end

  always_ff @(posedge clk) begin
    p_fl       <= 29'(flow) * 29'(h_s);
    p_rt       <= 37'(rate) * 37'(h_s);
    p_sc       <= 46'(p_fl) * 46'($signed({1'b0, vel_gain}));
    p_gy       <= 62'(p_rt) * 62'($signed({1'b0, gyro_gain}));
    scaled     <= sc_sat;
    comp       <= ctrl.scale_en ? comp_val : 39'sd0;
    p_old      <= 37'(filter_in) * 37'($signed({1'b0, old_w}));
    p_new      <= 57'(comp) * 57'($signed({1'b0, new_w}));
    filter_out <= sat19({{22{tr[57]}}, tr[57:16]});
  end

endmodule

`default_nettype wire
